// ===== sv/sspd_pkg.sv =====
// shared constants, register codes and types for the slope sum peak detector
package sspd_pkg;

   localparam int WINDOW          = 32;
   localparam int HISTORY_DEPTH   = 16;
   localparam int SAMPLE_BITS     = 12;
   localparam int TOTAL_BITS      = 17;
   localparam int LAG_BITS        = 3;
   localparam int MARGIN_BITS     = 17;
   localparam int LIMIT_BITS      = 16;
   localparam int COUNT_BITS      = LIMIT_BITS + 1;
   localparam int HIST_ADDR_BITS  = $clog2(HISTORY_DEPTH);
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_ADDR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 17;

   localparam logic [LAG_BITS-1:0]    PEAK_LAG_RESET         = LAG_BITS'(6);
   localparam logic [MARGIN_BITS-1:0] PEAK_MARGIN_RESET      = MARGIN_BITS'(2);
   localparam logic [LIMIT_BITS-1:0]  REFRACTORY_LIMIT_RESET = LIMIT_BITS'(50);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PEAK_LAG         = 2'd0,
      CSR_PEAK_MARGIN      = 2'd1,
      CSR_REFRACTORY_LIMIT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [LAG_BITS-1:0]    peak_lag;
      logic [MARGIN_BITS-1:0] peak_margin;
      logic [LIMIT_BITS-1:0]  refractory_limit;
   } sspd_cfg_type;

   // one slope total moving between front, queue and back
   typedef struct packed {
      logic                  valid;
      logic [TOTAL_BITS-1:0] total;
   } sspd_slot_type;

endpackage

// ===== sv/sspd_front.sv =====
// front end: sample window shift line and running positive slope total
module sspd_front
   import sspd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  logic                   q_full,
   output sspd_slot_type          push
);

   logic [SAMPLE_BITS-1:0] window_ff [WINDOW];
   logic [TOTAL_BITS-1:0]  acc_ff;
   logic [TOTAL_BITS-1:0]  acc_in;
   logic [TOTAL_BITS-1:0]  slope_drop;
   logic [TOTAL_BITS-1:0]  slope_add;
   logic                   accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   // tap 0 is the newest sample, the last tap the oldest
   always_comb begin
      slope_drop = '0;
      slope_add  = '0;
      if (window_ff[WINDOW-2] > window_ff[WINDOW-1]) begin
         slope_drop = TOTAL_BITS'(window_ff[WINDOW-2] - window_ff[WINDOW-1]);
      end
      if (req_sample > window_ff[0]) begin
         slope_add = TOTAL_BITS'(req_sample - window_ff[0]);
      end
      acc_in = acc_ff - slope_drop + slope_add;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         for (int i = 0; i < WINDOW; i++) begin
            window_ff[i] <= '0;
         end
      end else if (accept) begin
         acc_ff       <= acc_in;
         window_ff[0] <= req_sample;
         for (int i = 1; i < WINDOW; i++) begin
            window_ff[i] <= window_ff[i-1];
         end
      end
   end

   assign push.valid = accept;
   assign push.total = acc_in;

endmodule

// ===== sv/sspd_queue.sv =====
// small fifo of slope totals between front and back
module sspd_queue
   import sspd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  sspd_slot_type push,
   input  logic          pop,
   output sspd_slot_type head,
   output logic          full
);

   logic [TOTAL_BITS-1:0]      slot_ff [QUEUE_DEPTH];
   logic [QUEUE_ADDR_BITS-1:0] wr_ptr_ff;
   logic [QUEUE_ADDR_BITS-1:0] rd_ptr_ff;
   logic [QUEUE_ADDR_BITS:0]   count_ff;
   logic [QUEUE_ADDR_BITS:0]   count_in;

   assign full       = (count_ff == (QUEUE_ADDR_BITS+1)'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.total = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push.valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push.valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push.valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wr_ptr_ff] <= push.total;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> (!full || pop))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("queue read while empty");

endmodule

// ===== sv/sspd_back.sv =====
// back end: slope total history, peak compare and refractory counter
module sspd_back
   import sspd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  sspd_cfg_type          cfg,
   input  sspd_slot_type         head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [TOTAL_BITS-1:0] rsp_slope_total,
   output logic                  rsp_peak_found
);

   logic [TOTAL_BITS-1:0]     hist_mem [HISTORY_DEPTH];
   logic [HISTORY_DEPTH-1:0]  hist_valid_ff;
   logic [HIST_ADDR_BITS-1:0] hist_head_ff;
   logic [HIST_ADDR_BITS-1:0] mid_addr;
   logic [HIST_ADDR_BITS-1:0] far_addr;

   logic                  s1_valid_ff;
   logic [TOTAL_BITS-1:0] cur_ff;
   logic [TOTAL_BITS-1:0] mid_ff;
   logic [TOTAL_BITS-1:0] far_ff;

   logic                  rsp_valid_ff;
   logic [TOTAL_BITS-1:0] rsp_total_ff;
   logic                  rsp_peak_ff;
   logic [COUNT_BITS-1:0] holdoff_ff;
   logic [COUNT_BITS-1:0] holdoff_in;
   logic [COUNT_BITS-1:0] limit_ext;

   logic                  out_free;
   logic                  s1_free;
   logic                  out_load;
   logic                  peak_in;
   logic [TOTAL_BITS:0]   far_bound;
   logic [TOTAL_BITS:0]   cur_bound;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s1_free  = !s1_valid_ff || out_free;
   assign pop      = head.valid && s1_free;
   assign out_load = s1_valid_ff && out_free;

   // a lag of zero lands on the slot being written and takes the bypass
   assign mid_addr = hist_head_ff - HIST_ADDR_BITS'(cfg.peak_lag);
   assign far_addr = hist_head_ff - HIST_ADDR_BITS'({cfg.peak_lag, 1'b0});

   always_ff @(posedge clock) begin
      if (pop) begin
         hist_mem[hist_head_ff] <= head.total;
      end
   end

   // history read with write bypass; never written slots read as zero
   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head.total;
         if (mid_addr == hist_head_ff) begin
            mid_ff <= head.total;
         end else begin
            mid_ff <= hist_valid_ff[mid_addr] ? hist_mem[mid_addr] : '0;
         end
         if (far_addr == hist_head_ff) begin
            far_ff <= head.total;
         end else begin
            far_ff <= hist_valid_ff[far_addr] ? hist_mem[far_addr] : '0;
         end
      end
   end

   always_comb begin
      limit_ext = COUNT_BITS'(cfg.refractory_limit);
      far_bound = (TOTAL_BITS+1)'(far_ff) + (TOTAL_BITS+1)'(cfg.peak_margin);
      cur_bound = (TOTAL_BITS+1)'(cur_ff) + (TOTAL_BITS+1)'(cfg.peak_margin);
      peak_in   = (holdoff_ff > limit_ext)
               && ((TOTAL_BITS+1)'(mid_ff) > far_bound)
               && ((TOTAL_BITS+1)'(mid_ff) > cur_bound);
      if (peak_in) begin
         holdoff_in = '0;
      end else if (holdoff_ff <= limit_ext) begin
         holdoff_in = holdoff_ff + 1'b1;
      end else begin
         holdoff_in = limit_ext + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_valid_ff <= '0;
         hist_head_ff  <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         holdoff_ff    <= '0;
      end else begin
         if (pop) begin
            hist_valid_ff[hist_head_ff] <= 1'b1;
            hist_head_ff                <= hist_head_ff + 1'b1;
         end
         if (s1_free) begin
            s1_valid_ff <= pop;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (out_load) begin
            holdoff_ff <= holdoff_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_total_ff <= cur_ff;
         rsp_peak_ff  <= peak_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_slope_total = rsp_total_ff;
   assign rsp_peak_found  = rsp_peak_ff;

   a_peak_clears_holdoff: assert property (@(posedge clock) disable iff (reset)
      (out_load && peak_in) |=> (holdoff_ff == '0))
      else $error("holdoff counter not cleared after a peak");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> (s1_valid_ff && $stable(cur_ff)
                                      && $stable(mid_ff) && $stable(far_ff)))
      else $error("compare stage lost its item under output stall");

endmodule

// ===== sv/slope_sum_peak_detector_top.sv =====
// top level of the slope sum peak detector: csr registers, front, queue and back
//
//   port group  direction  handshake              payload
//   req_        in         req_valid / req_stall  req_sample[11:0]
//   rsp_        out        rsp_valid / rsp_stall  rsp_slope_total[16:0], rsp_peak_found
//   csr_        in         csr_write              csr_index[1:0], csr_wdata[16:0]
//
// one item per cycle sustained while rsp_stall is low; from req accept to rsp_valid
// an item passes the queue write, history read and output register
// the per-item loop is the refractory counter update in the back end
// a four-entry queue absorbs rsp_stall; req_stall rises only when it is full
// reset clears window, running total, history valid bits and counter, csr to defaults
module slope_sum_peak_detector_top
   import sspd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [SAMPLE_BITS-1:0]    req_sample,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [TOTAL_BITS-1:0]     rsp_slope_total,
   output logic                      rsp_peak_found,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   sspd_cfg_type  cfg_ff;
   sspd_slot_type push;
   sspd_slot_type head;
   logic          q_full;
   logic          pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.peak_lag         <= PEAK_LAG_RESET;
         cfg_ff.peak_margin      <= PEAK_MARGIN_RESET;
         cfg_ff.refractory_limit <= REFRACTORY_LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_PEAK_LAG: begin
               cfg_ff.peak_lag <= csr_wdata[LAG_BITS-1:0];
            end
            CSR_PEAK_MARGIN: begin
               cfg_ff.peak_margin <= csr_wdata[MARGIN_BITS-1:0];
            end
            CSR_REFRACTORY_LIMIT: begin
               cfg_ff.refractory_limit <= csr_wdata[LIMIT_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   sspd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .q_full     (q_full),
      .push       (push)
   );

   sspd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (q_full)
   );

   sspd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_slope_total (rsp_slope_total),
      .rsp_peak_found  (rsp_peak_found)
   );

endmodule

// ===== bench/tb_top.sv =====
// self-checking testbench for the slope sum peak detector top level
`timescale 1ns / 1ps

module tb_top;
   import sspd_pkg::*;

   localparam int WIN_ADDR_BITS = $clog2(WINDOW);
   localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;
   localparam int RUN_LIMIT     = 400000;

   typedef struct packed {
      logic [TOTAL_BITS-1:0] total;
      logic                  peak;
   } slope_out_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [SAMPLE_BITS-1:0] req_sample = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [TOTAL_BITS-1:0]  rsp_slope_total;
   logic                   rsp_peak_found;
   logic                   csr_write = 1'b0;
   csr_index_type          csr_index = CSR_PEAK_LAG;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // detector state kept alongside the block
   logic [SAMPLE_BITS-1:0]    window_q [WINDOW];
   logic [WIN_ADDR_BITS-1:0]  window_head = '0;
   logic [TOTAL_BITS-1:0]     rise_total = '0;
   logic [TOTAL_BITS-1:0]     total_ring [HISTORY_DEPTH];
   logic [HIST_ADDR_BITS-1:0] ring_head = '0;
   logic [COUNT_BITS-1:0]     holdoff = '0;
   logic [LAG_BITS-1:0]       lag_cfg = PEAK_LAG_RESET;
   logic [MARGIN_BITS-1:0]    margin_cfg = PEAK_MARGIN_RESET;
   logic [LIMIT_BITS-1:0]     limit_cfg = REFRACTORY_LIMIT_RESET;

   logic [SAMPLE_BITS-1:0] samples_to_send [$];
   slope_out_type          sums_due [$];
   int                     mismatch_count = 0;
   int                     cycle_count = 0;
   int                     send_gap = 0;
   int                     stall_left = 0;
   bit                     send_burst = 1'b0;
   bit                     recv_burst = 1'b0;

   slope_sum_peak_detector_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_slope_total (rsp_slope_total),
      .rsp_peak_found  (rsp_peak_found),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("slope_sum_peak_detector_top test failed");
         $finish;
      end
   end

   // one sample in: update window, running total, history and holdoff counter
   function automatic slope_out_type slope_peak_step(input logic [SAMPLE_BITS-1:0] x);
      logic [SAMPLE_BITS-1:0] oldest;
      logic [SAMPLE_BITS-1:0] second;
      logic [SAMPLE_BITS-1:0] newest;
      int                     cur;
      int                     mid;
      int                     far;
      int                     margin;
      logic                   peak;
      slope_out_type          res;
      oldest = window_q[window_head];
      second = window_q[WIN_ADDR_BITS'(window_head + 1)];
      newest = window_q[WIN_ADDR_BITS'(window_head - 1)];
      if (second > oldest) rise_total = rise_total - (second - oldest);
      if (x > newest) rise_total = rise_total + (x - newest);
      window_q[window_head] = x;
      window_head = window_head + 1'b1;
      total_ring[ring_head] = rise_total;
      cur = total_ring[ring_head];
      mid = total_ring[HIST_ADDR_BITS'(ring_head - lag_cfg)];
      far = total_ring[HIST_ADDR_BITS'(ring_head - 2 * lag_cfg)];
      ring_head = ring_head + 1'b1;
      margin = margin_cfg;
      peak = (holdoff > limit_cfg) && (mid - far > margin) && (mid - cur > margin);
      if (peak) begin
         holdoff = '0;
      end else if (holdoff <= limit_cfg) begin
         holdoff = holdoff + 1'b1;
      end else begin
         holdoff = limit_cfg + 1'b1;
      end
      res.total = rise_total;
      res.peak  = peak;
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 30) $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   // sender: random idle gap after each item, with stretches of back-to-back items
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (!req_valid || !req_stall) begin
         if (send_gap != 0) begin
            req_valid <= 1'b0;
            send_gap  <= send_gap - 1;
         end else if (samples_to_send.size() != 0) begin
            req_valid  <= 1'b1;
            req_sample <= samples_to_send.pop_front();
            if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
            send_gap <= send_burst ? 0 : $urandom_range(0, 8);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: predicts on each accepted sample, checks each accepted result
   always @(posedge clock) begin : receive
      slope_out_type due;
      int            hold;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (req_valid && !req_stall) sums_due.push_back(slope_peak_step(req_sample));
         hold = stall_left;
         if (rsp_valid && !rsp_stall) begin
            if (sums_due.size() == 0) begin
               report_mismatch("result with no item due");
            end else begin
               due = sums_due.pop_front();
               if (rsp_slope_total !== due.total)
                  report_mismatch($sformatf("slope_total %0d, due %0d",
                                            rsp_slope_total, due.total));
               if (rsp_peak_found !== due.peak)
                  report_mismatch($sformatf("peak_found %0b, due %0b",
                                            rsp_peak_found, due.peak));
            end
            if ($urandom_range(0, 31) == 0) recv_burst = !recv_burst;
            hold = recv_burst ? 0 : $urandom_range(0, 8);
         end else if (hold != 0) begin
            hold = hold - 1;
         end
         stall_left <= hold;
         rsp_stall  <= (hold != 0);
      end
   end

   task automatic push_sample(input int v);
      if (v < 0) v = 0;
      else if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      samples_to_send.push_back(SAMPLE_BITS'(v));
   endtask

   function automatic int jiggle(input int spread);
      if (spread == 0) return 0;
      return int'($urandom_range(0, spread)) - spread / 2;
   endfunction

   // pulse shaped like a beat: ramp up, ramp down, then a resting stretch
   task automatic push_pulse();
      int base;
      int amp;
      int rise;
      int fall;
      int rest;
      int spread;
      int k;
      base   = $urandom_range(0, 1500);
      amp    = $urandom_range(200, SAMPLE_MAX - base);
      rise   = $urandom_range(1, 10);
      fall   = $urandom_range(2, 24);
      rest   = $urandom_range(0, 40);
      spread = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 200) : 0;
      for (k = 1; k <= rise; k++) push_sample(base + amp * k / rise + jiggle(spread));
      for (k = fall - 1; k >= 0; k--) push_sample(base + amp * k / fall + jiggle(spread));
      for (k = 0; k < rest; k++) push_sample(base + jiggle(spread));
   endtask

   task automatic fill_random(input int count);
      int target;
      int pick;
      int len;
      int level;
      int k;
      target = samples_to_send.size() + count;
      while (samples_to_send.size() < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            push_pulse();
         end else if (pick < 75) begin
            len = $urandom_range(4, 20);
            for (k = 0; k < len; k++) push_sample($urandom_range(0, SAMPLE_MAX));
         end else if (pick < 85) begin
            // full swing alternation drives the total toward its largest value
            len = $urandom_range(8, 40);
            for (k = 0; k < len; k++) push_sample((k % 2 == 0) ? 0 : SAMPLE_MAX);
         end else begin
            len   = $urandom_range(4, 30);
            level = $urandom_range(0, SAMPLE_MAX);
            for (k = 0; k < len; k++) push_sample(level);
         end
      end
      // cut the last shape short so the phase sends exactly count items
      while (samples_to_send.size() > target) void'(samples_to_send.pop_back());
   endtask

   task automatic write_csr(input csr_index_type idx, input int value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_BITS'(value);
      case (idx)
         CSR_PEAK_LAG:         lag_cfg = LAG_BITS'(value);
         CSR_PEAK_MARGIN:      margin_cfg = MARGIN_BITS'(value);
         CSR_REFRACTORY_LIMIT: limit_cfg = LIMIT_BITS'(value);
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic apply_settings(input int lag, input int margin, input int limit);
      write_csr(CSR_PEAK_LAG, lag);
      write_csr(CSR_PEAK_MARGIN, margin);
      write_csr(CSR_REFRACTORY_LIMIT, limit);
      @(negedge clock);
   endtask

   // every item gives one result, so no results due means the block is idle
   task automatic wait_drained();
      @(negedge clock);
      while (samples_to_send.size() != 0 || req_valid || sums_due.size() != 0)
         @(negedge clock);
   endtask

   task automatic run_phase(input int lag, input int margin, input int limit,
                            input int count);
      apply_settings(lag, margin, limit);
      fill_random(count);
      wait_drained();
   endtask

   initial begin
      int extreme_samples[12];
      int zero_lag_samples[13];
      int lag_pick;
      int margin_pick;
      int limit_pick;
      int k;
      extreme_samples  = '{4095, 0, 4095, 0, 1, 4094, 2048, 2047, 4095, 4095, 0, 0};
      zero_lag_samples = '{0, 3000, 3000, 3000, 0, 0, 2000, 0, 4095, 4095, 0, 0, 0};
      for (k = 0; k < WINDOW; k++) window_q[k] = '0;
      for (k = 0; k < HISTORY_DEPTH; k++) total_ring[k] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // startup with register defaults: zeroed window and history take part
      @(negedge clock);
      for (k = 0; k < 12; k++) push_sample(extreme_samples[k]);
      wait_drained();

      // zero lag compares the current total with itself
      apply_settings(0, 0, 0);
      for (k = 0; k < 13; k++) push_sample(zero_lag_samples[k]);
      wait_drained();

      run_phase(1, 0, 0, 80);
      run_phase(7, 131071, 65535, 80);
      // counter has climbed far above the new limit and gets pulled down
      run_phase(4, 5, 2, 80);
      run_phase(7, 0, 10, 60);
      for (k = 0; k < 7; k++) begin
         lag_pick    = $urandom_range(1, 7);
         margin_pick = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071)
                                                  : $urandom_range(0, 400);
         limit_pick  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535)
                                                  : $urandom_range(0, 25);
         run_phase(lag_pick, margin_pick, limit_pick, 70);
      end
      run_phase(0, 0, 0, 30);

      repeat (12) @(negedge clock);
      if (mismatch_count == 0 && sums_due.size() == 0)
         $display("slope_sum_peak_detector_top test passed");
      else
         $display("slope_sum_peak_detector_top test failed");
      $finish;
   end

endmodule
